// ===== rtl/kpd_pkg.sv =====
package kpd_pkg;

	// Key codes 0..15 name a key, this code means no key.
	localparam logic [4:0] NO_KEY_CODE = 5'd16;

	typedef enum logic [1:0] {
		REG_MIRROR_COLUMNS = 2'd0,
		REG_MIRROR_ROWS    = 2'd1,
		REG_DEBOUNCE_READS = 2'd2
	} kpd_reg_t;

	localparam logic [3:0] DEBOUNCE_RESET = 4'd2;

	// Decoded scan passed from the decoder to the debounce logic.
	typedef struct packed {
		logic       drop;
		logic [4:0] code;
	} kpd_scan_t;

	// Layout 123A/456B/789C/*0#D; mask bits are A,B,X,Y,L,R,ZL,ZR,minus,plus,home.
	function automatic logic [10:0] key_buttons(input logic [3:0] key);
		logic [10:0] mask;
		unique case (key)
			4'd0:    mask = 11'h010;
			4'd2:    mask = 11'h020;
			4'd3:    mask = 11'h001;
			4'd7:    mask = 11'h002;
			4'd8:    mask = 11'h040;
			4'd10:   mask = 11'h080;
			4'd11:   mask = 11'h004;
			4'd12:   mask = 11'h100;
			4'd13:   mask = 11'h400;
			4'd14:   mask = 11'h200;
			4'd15:   mask = 11'h008;
			default: mask = 11'h000;
		endcase
		return mask;
	endfunction

	function automatic logic [3:0] key_dirs(input logic [3:0] key);
		logic [3:0] dirs;
		unique case (key)
			4'd1:    dirs = 4'h1;
			4'd4:    dirs = 4'h4;
			4'd6:    dirs = 4'h8;
			4'd9:    dirs = 4'h2;
			default: dirs = 4'h0;
		endcase
		return dirs;
	endfunction

endpackage

// ===== rtl/kpd_if.sv =====
interface kpd_scan_if;
	logic       valid;
	logic       ready;
	logic [3:0] column_lines;
	logic [3:0] row_lines;
	logic       bus_error;

	modport source (output valid, output column_lines, output row_lines, output bus_error,
		input ready);
	modport sink (input valid, input column_lines, input row_lines, input bus_error,
		output ready);
endinterface

interface kpd_event_if;
	logic        valid;
	logic        ready;
	logic [3:0]  key_index;
	logic        key_pressed;
	logic [10:0] button_mask;
	logic [3:0]  direction_bits;

	modport source (output valid, output key_index, output key_pressed,
		output button_mask, output direction_bits, input ready);
	modport sink (input valid, input key_index, input key_pressed,
		input button_mask, input direction_bits, output ready);
endinterface

// ===== rtl/kpd_scan_decode.sv =====
module kpd_scan_decode
	import kpd_pkg::*;
(
	input  logic [3:0] column_lines,
	input  logic [3:0] row_lines,
	input  logic       bus_error,
	input  logic       mirror_columns,
	input  logic       mirror_rows,
	output kpd_scan_t  scan
);

	typedef struct packed {
		logic       none;
		logic       many;
		logic [1:0] idx;
	} kpd_lines_t;

	function automatic kpd_lines_t decode_lines(input logic [3:0] nib);
		kpd_lines_t d;
		d = '0;
		unique case (nib)
			4'hE:    d.idx = 2'd0;
			4'hD:    d.idx = 2'd1;
			4'hB:    d.idx = 2'd2;
			4'h7:    d.idx = 2'd3;
			4'hF:    d.none = 1'b1;
			default: d.many = 1'b1;
		endcase
		return d;
	endfunction

	kpd_lines_t col_d;
	kpd_lines_t row_d;
	logic [1:0] col;
	logic [1:0] row;

	assign col_d = decode_lines(column_lines);
	assign row_d = decode_lines(row_lines);

	// Mirroring 3-c is the bitwise inverse of a two-bit index.
	assign col = mirror_columns ? ~col_d.idx : col_d.idx;
	assign row = mirror_rows ? ~row_d.idx : row_d.idx;

	// The row nibble only matters when exactly one column line is low.
	always_comb begin
		scan.drop = 1'b0;
		scan.code = NO_KEY_CODE;
		priority if (bus_error || col_d.many) begin
			scan.drop = 1'b1;
		end else if (col_d.none) begin
			scan.code = NO_KEY_CODE;
		end else if (row_d.many) begin
			scan.drop = 1'b1;
		end else if (row_d.none) begin
			scan.code = NO_KEY_CODE;
		end else begin
			scan.code = {1'b0, row, col};
		end
	end

endmodule

// ===== rtl/keypad_scan_debounce_mapper_top.sv =====
// Channel  Dir  Payload                                              Accepted when
// scan     in   column_lines[3:0], row_lines[3:0], bus_error         valid && ready
// report   out  key_index[3:0], key_pressed, button_mask[10:0],      valid && ready
//               direction_bits[3:0]
// config   in   write_enable, reg_index[1:0], write_data[3:0]        write_enable
//
// A scan word is registered in the input register on entry, then decoded and debounced,
// and its event is registered in the output register that drives report.
// One scan word is taken every cycle while the output register can move.
// The debounce state advances only when the input register hands its word on,
// which stalls while an event waits in the output register and report.ready is low.
// Reset clears the stable key and the candidate to no key and the count to zero.
module keypad_scan_debounce_mapper_top
	import kpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	kpd_scan_if.sink    scan,
	kpd_event_if.source report,
	input  logic        write_enable,
	input  logic [1:0]  reg_index,
	input  logic [3:0]  write_data
);

	logic       mirror_columns_q;
	logic       mirror_rows_q;
	logic [3:0] debounce_reads_q;

	logic       valid_s1;
	logic [3:0] column_lines_s1;
	logic [3:0] row_lines_s1;
	logic       bus_error_s1;

	logic [4:0] stable_code_q;
	logic [4:0] candidate_code_q;
	logic [3:0] repeat_count_q;

	logic        out_valid_q;
	logic [3:0]  key_index_q;
	logic        key_pressed_q;
	logic [10:0] button_mask_q;
	logic [3:0]  direction_bits_q;

	kpd_scan_t  dec;
	logic       advance;
	logic       update;
	logic [3:0] count_next;
	logic       emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_columns_q <= 1'b0;
			mirror_rows_q    <= 1'b0;
			debounce_reads_q <= DEBOUNCE_RESET;
		end else if (write_enable) begin
			unique case (reg_index)
				REG_MIRROR_COLUMNS: mirror_columns_q <= write_data[0];
				REG_MIRROR_ROWS:    mirror_rows_q    <= write_data[0];
				REG_DEBOUNCE_READS: debounce_reads_q <= write_data;
				default: ;
			endcase
		end
	end

	assign advance     = !out_valid_q || report.ready;
	assign scan.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.ready && scan.valid) begin
			column_lines_s1 <= scan.column_lines;
			row_lines_s1    <= scan.row_lines;
			bus_error_s1    <= scan.bus_error;
		end
	end

	kpd_scan_decode u_decode (
		.column_lines   (column_lines_s1),
		.row_lines      (row_lines_s1),
		.bus_error      (bus_error_s1),
		.mirror_columns (mirror_columns_q),
		.mirror_rows    (mirror_rows_q),
		.scan           (dec)
	);

	// The count saturates at the configured number of reads.
	always_comb begin
		if (dec.code == candidate_code_q) begin
			count_next = (repeat_count_q < debounce_reads_q) ? repeat_count_q + 4'd1
				: repeat_count_q;
		end else begin
			count_next = 4'd1;
		end
	end

	assign update = valid_s1 && advance && !dec.drop;
	assign emit   = (count_next >= debounce_reads_q) && (dec.code != stable_code_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_code_q    <= NO_KEY_CODE;
			candidate_code_q <= NO_KEY_CODE;
			repeat_count_q   <= 4'd0;
		end else if (update) begin
			candidate_code_q <= dec.code;
			repeat_count_q   <= count_next;
			if (emit) begin
				stable_code_q <= dec.code;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= update && emit;
		end
	end

	// A release word carries all zeros.
	always_ff @(posedge clk) begin
		if (update && emit) begin
			if (dec.code[4]) begin
				key_index_q      <= 4'd0;
				key_pressed_q    <= 1'b0;
				button_mask_q    <= 11'd0;
				direction_bits_q <= 4'd0;
			end else begin
				key_index_q      <= dec.code[3:0];
				key_pressed_q    <= 1'b1;
				button_mask_q    <= key_buttons(dec.code[3:0]);
				direction_bits_q <= key_dirs(dec.code[3:0]);
			end
		end
	end

	assign report.valid          = out_valid_q;
	assign report.key_index      = key_index_q;
	assign report.key_pressed    = key_pressed_q;
	assign report.button_mask    = button_mask_q;
	assign report.direction_bits = direction_bits_q;

endmodule
